// ----- rtl/core/cbi_pkg.sv -----
// Shared types, widths and register codes of the clipped rectangle blit index block.
package cbi_pkg;

  localparam int MAX_DIM = 4096;

  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int BASE_W     = 25;
  localparam int IDX_W      = 24;
  localparam int PIX_W      = 32;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 3'd5;

  localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 13'd400;
  localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 13'd300;

  typedef struct packed {
    logic [POS_W-1:0] rect_x;
    logic [POS_W-1:0] rect_y;
    logic [DIM_W-1:0] rect_w;
    logic [DIM_W-1:0] rect_h;
    logic [DIM_W-1:0] fb_width;
    logic [DIM_W-1:0] fb_height;
  } cbi_cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  fw;
    logic [DIM_W-1:0]  wr;
    logic [DIM_W-1:0]  hr;
    logic              empty;
    logic [BASE_W-1:0] start_base;
  } cbi_geom_t;

endpackage

// ----- rtl/core/cbi_if.sv -----
// Stream interfaces for source pixel items and result items.
interface cbi_pix_if;
  logic                     valid;
  logic                     ready;
  logic [cbi_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface cbi_res_if;
  logic                      valid;
  logic                      ready;
  logic                      write_valid;
  logic [cbi_pkg::IDX_W-1:0] fb_index;
  logic [cbi_pkg::PIX_W-1:0] pixel_out;
  logic                      rect_done;

  modport source (output valid, output write_valid, output fb_index, output pixel_out,
                  output rect_done, input ready);
  modport sink (input valid, input write_valid, input fb_index, input pixel_out,
                input rect_done, output ready);
endinterface

// ----- rtl/core/clipped_rect_blit_index_top.sv -----
// Top level of the clipped rectangle blit index generator.
//
//  port        dir   payload                                         role
//  pixel       sink  pixel_value[31:0]                               source pixel items
//  result      src   write_valid, fb_index[23:0], pixel_out, rect_done  one per pixel item
//  cfg_*       in    cfg_wr_en, cfg_index[2:0], cfg_data[12:0]       register writes
//
// One item per cycle sustained while the result is not stalled; each result passes through
// the input register and then the result register. These two registers part the two sides; the counter and row base
// update with a single add in the step from one to the other.
// Synchronous reset clears the counters and valid flags and loads the register defaults.
// A stalled result holds the pipeline; pixel.ready stays high while the input register
// can move on.
module clipped_rect_blit_index_top (
  input  logic                               clk,
  input  logic                               rst,
  cbi_pix_if.sink                            pixel,
  cbi_res_if.source                          result,
  input  logic                               cfg_wr_en,
  input  logic [cbi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cbi_pkg::cbi_cfg_t  cfg;
  cbi_pkg::cbi_geom_t geom;

  logic                       s1_valid;
  logic [cbi_pkg::PIX_W-1:0]  s1_pixel;
  logic                       out_valid;
  logic                       out_write_valid;
  logic [cbi_pkg::IDX_W-1:0]  out_fb_index;
  logic [cbi_pkg::PIX_W-1:0]  out_pixel;
  logic                       out_done;

  logic [cbi_pkg::DIM_W-1:0]  col_count;
  logic [cbi_pkg::DIM_W-1:0]  row_count;
  logic [cbi_pkg::BASE_W-1:0] row_base;
  logic [cbi_pkg::DIM_W-1:0]  col_count_next;
  logic [cbi_pkg::DIM_W-1:0]  row_count_next;
  logic [cbi_pkg::BASE_W-1:0] row_base_next;

  logic                       advance;
  logic                       step;
  logic                       cfg_hit;
  logic [cbi_pkg::BASE_W-1:0] base_cur;
  logic [cbi_pkg::BASE_W-1:0] index_sum;
  logic [cbi_pkg::DIM_W:0]    col_inc;
  logic [cbi_pkg::DIM_W:0]    row_inc;
  logic                       col_end;
  logic                       row_end;
  logic                       hit;
  logic                       last;

  cbi_geom u_geom (
    .clk  (clk),
    .cfg  (cfg),
    .geom (geom)
  );

  assign advance     = !out_valid || result.ready;
  assign step        = s1_valid && advance;
  assign pixel.ready = !s1_valid || advance;

  assign cfg_hit = cfg_wr_en && (cfg_index <= cbi_pkg::REG_FB_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_x    <= '0;
      cfg.rect_y    <= '0;
      cfg.rect_w    <= '0;
      cfg.rect_h    <= '0;
      cfg.fb_width  <= cbi_pkg::FB_WIDTH_RST;
      cfg.fb_height <= cbi_pkg::FB_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cbi_pkg::REG_RECT_X:    cfg.rect_x    <= cfg_data[cbi_pkg::POS_W-1:0];
        cbi_pkg::REG_RECT_Y:    cfg.rect_y    <= cfg_data[cbi_pkg::POS_W-1:0];
        cbi_pkg::REG_RECT_W:    cfg.rect_w    <= cfg_data;
        cbi_pkg::REG_RECT_H:    cfg.rect_h    <= cfg_data;
        cbi_pkg::REG_FB_WIDTH:  cfg.fb_width  <= cfg_data;
        cbi_pkg::REG_FB_HEIGHT: cfg.fb_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    base_cur  = ((col_count == '0) && (row_count == '0)) ? geom.start_base : row_base;
    col_inc   = {1'b0, col_count} + 14'd1;
    row_inc   = {1'b0, row_count} + 14'd1;
    col_end   = col_inc >= {1'b0, geom.w};
    row_end   = row_inc >= {1'b0, geom.h};
    hit       = !geom.empty && (col_count < geom.wr) && (row_count < geom.hr);
    index_sum = base_cur + {12'd0, col_count};
    last      = geom.empty || (col_end && row_end);
    if (last) begin
      col_count_next = '0;
      row_count_next = '0;
      row_base_next  = base_cur;
    end else if (col_end) begin
      col_count_next = '0;
      row_count_next = row_inc[cbi_pkg::DIM_W-1:0];
      row_base_next  = base_cur + {12'd0, geom.fw};
    end else begin
      col_count_next = col_inc[cbi_pkg::DIM_W-1:0];
      row_count_next = row_count;
      row_base_next  = base_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (step) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      row_base <= row_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pixel.ready) begin
        s1_valid <= pixel.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      s1_pixel <= pixel.pixel_value;
    end
    if (step) begin
      out_write_valid <= hit;
      out_fb_index    <= hit ? index_sum[cbi_pkg::IDX_W-1:0] : '0;
      out_pixel       <= s1_pixel;
      out_done        <= last;
    end
  end

  assign result.valid       = out_valid;
  assign result.write_valid = out_write_valid;
  assign result.fb_index    = out_fb_index;
  assign result.pixel_out   = out_pixel;
  assign result.rect_done   = out_done;

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (col_count == '0) && (row_count == '0))
    else $error("Counters not cleared after a register write.");

  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    (step && last && !cfg_hit) |=> (col_count == '0) && (row_count == '0))
    else $error("Counters did not wrap after the last pixel.");

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("A moved item did not reach the result register.");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_write_valid) |-> (out_fb_index == '0))
    else $error("Index is nonzero on a clipped pixel.");

endmodule

// ----- rtl/core/cbi_geom.sv -----
// Registered clip geometry and start index derived from the configuration registers.
module cbi_geom (
  input  logic               clk,
  input  cbi_pkg::cbi_cfg_t  cfg,
  output cbi_pkg::cbi_geom_t geom
);

  logic [cbi_pkg::POS_W-1:0]  x;
  logic [cbi_pkg::POS_W-1:0]  y;
  logic [cbi_pkg::DIM_W-1:0]  w;
  logic [cbi_pkg::DIM_W-1:0]  h;
  logic [cbi_pkg::DIM_W-1:0]  fw;
  logic [cbi_pkg::DIM_W-1:0]  fh;
  logic [cbi_pkg::DIM_W:0]    x_end;
  logic [cbi_pkg::DIM_W:0]    y_end;
  logic [cbi_pkg::DIM_W-1:0]  wr;
  logic [cbi_pkg::DIM_W-1:0]  hr;
  logic [cbi_pkg::BASE_W-1:0] base;

  localparam logic [cbi_pkg::POS_W-1:0] POS_MAX = cbi_pkg::POS_W'(cbi_pkg::MAX_DIM - 1);
  localparam logic [cbi_pkg::DIM_W-1:0] DIM_MAX = cbi_pkg::DIM_W'(cbi_pkg::MAX_DIM);

  always_comb begin
    x     = (cfg.rect_x > POS_MAX) ? POS_MAX : cfg.rect_x;
    y     = (cfg.rect_y > POS_MAX) ? POS_MAX : cfg.rect_y;
    w     = (cfg.rect_w > DIM_MAX) ? DIM_MAX : cfg.rect_w;
    h     = (cfg.rect_h > DIM_MAX) ? DIM_MAX : cfg.rect_h;
    fw    = (cfg.fb_width > DIM_MAX) ? DIM_MAX : cfg.fb_width;
    fh    = (cfg.fb_height > DIM_MAX) ? DIM_MAX : cfg.fb_height;
    x_end = {2'b00, x} + {1'b0, w};
    y_end = {2'b00, y} + {1'b0, h};
    if (x_end <= {1'b0, fw}) begin
      wr = w;
    end else if ({1'b0, x} > fw) begin
      wr = '0;
    end else begin
      wr = fw - {1'b0, x};
    end
    if (y_end <= {1'b0, fh}) begin
      hr = h;
    end else if ({1'b0, y} > fh) begin
      hr = '0;
    end else begin
      hr = fh - {1'b0, y};
    end
    base = ({13'd0, y} * {12'd0, fw}) + {13'd0, x};
  end

  always_ff @(posedge clk) begin
    geom.w          <= w;
    geom.h          <= h;
    geom.fw         <= fw;
    geom.wr         <= wr;
    geom.hr         <= hr;
    geom.empty      <= (w == '0) || (h == '0);
    geom.start_base <= base;
  end

endmodule

// ----- bench/cbi_blit_checker.sv -----
// Result checker for the clipped rectangle blit index block: predicts every result item and compares.
module cbi_blit_checker
  import cbi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  cbi_pix_if                    pix,
  cbi_res_if                    res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             write_valid;
    logic [IDX_W-1:0] fb_index;
    logic [PIX_W-1:0] pixel_out;
    logic             rect_done;
  } blit_result_t;

  cbi_cfg_t          regs;
  logic [DIM_W-1:0]  col_pos;
  logic [DIM_W-1:0]  row_pos;
  logic [BASE_W-1:0] row_base;
  blit_result_t      expected_q[$];
  blit_result_t      want;

  function automatic int unsigned cap(input int unsigned v, input int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned clip_span(input int unsigned pos, input int unsigned len,
                                            input int unsigned lim);
    if (pos + len <= lim) return len;
    return (pos > lim) ? 0 : lim - pos;
  endfunction

  function automatic blit_result_t blit_step(input logic [PIX_W-1:0] pixel);
    int unsigned  x, y, w, h, fw, fh, wr, hr;
    logic         empty, last;
    blit_result_t r;
    x  = cap(regs.rect_x, MAX_DIM - 1);
    y  = cap(regs.rect_y, MAX_DIM - 1);
    w  = cap(regs.rect_w, MAX_DIM);
    h  = cap(regs.rect_h, MAX_DIM);
    fw = cap(regs.fb_width, MAX_DIM);
    fh = cap(regs.fb_height, MAX_DIM);
    wr = clip_span(x, w, fw);
    hr = clip_span(y, h, fh);
    empty = (w == 0) || (h == 0);
    if (col_pos == '0 && row_pos == '0) row_base = BASE_W'(y * fw + x);
    r.write_valid = !empty && (col_pos < wr) && (row_pos < hr);
    r.fb_index    = r.write_valid ? IDX_W'(row_base + col_pos) : '0;
    r.pixel_out   = pixel;
    last = empty || ((col_pos + 1 >= w) && (row_pos + 1 >= h));
    r.rect_done   = last;
    if (last) begin
      col_pos = '0;
      row_pos = '0;
    end else if (col_pos + 1 >= w) begin
      col_pos  = '0;
      row_pos  = row_pos + 1'b1;
      row_base = BASE_W'(row_base + fw);
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string msg);
    if (mismatches < 40) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                             input logic [PIX_W-1:0] exp_val);
    if (got !== exp_val) report($sformatf("%s is %0h, should be %0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs           = '0;
      regs.fb_width  = FB_WIDTH_RST;
      regs.fb_height = FB_HEIGHT_RST;
      col_pos        = '0;
      row_pos        = '0;
      row_base       = '0;
      expected_q.delete();
      mismatches     = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RECT_X:    regs.rect_x    = cfg_data[POS_W-1:0];
          REG_RECT_Y:    regs.rect_y    = cfg_data[POS_W-1:0];
          REG_RECT_W:    regs.rect_w    = cfg_data;
          REG_RECT_H:    regs.rect_h    = cfg_data;
          REG_FB_WIDTH:  regs.fb_width  = cfg_data;
          REG_FB_HEIGHT: regs.fb_height = cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_FB_HEIGHT) begin
          col_pos = '0;
          row_pos = '0;
        end
      end
      if (pix.valid && pix.ready) expected_q.push_back(blit_step(pix.pixel_value));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report("result item arrived with no pixel item outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("write_valid", PIX_W'(res.write_valid), PIX_W'(want.write_valid));
          check_field("fb_index", PIX_W'(res.fb_index), PIX_W'(want.fb_index));
          check_field("pixel_out", res.pixel_out, want.pixel_out);
          check_field("rect_done", PIX_W'(res.rect_done), PIX_W'(want.rect_done));
        end
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the clipped rectangle blit index block: stimulus, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] ALL_REGS [6] = '{REG_RECT_X, REG_RECT_Y, REG_RECT_W,
                                                    REG_RECT_H, REG_FB_WIDTH, REG_FB_HEIGHT};
  localparam int ITEM_TARGET = 1950;
  localparam int QUIET_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending_results;
  int                    items_sent;
  int                    writes_seen;
  int                    rects_done;
  int                    quiet_cycles;
  int                    settings_used;
  int                    pat_age = 0;
  int                    pat_pos = 0;
  logic [15:0]           stall_pat = '1;
  logic [DIM_W-1:0]      plan_w;
  logic [DIM_W-1:0]      plan_h;
  logic [PIX_W-1:0]      directed_pix[$];

  cbi_pix_if pix_bus();
  cbi_res_if res_bus();

  clipped_rect_blit_index_top i_dut (
    .clk,
    .rst,
    .pixel     (pix_bus),
    .result    (res_bus),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data
  );

  cbi_blit_checker i_checker (
    .clk,
    .rst,
    .pix             (pix_bus),
    .res             (res_bus),
    .cfg_wr_en,
    .cfg_index,
    .cfg_data,
    .mismatches,
    .pending_results
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      items_sent   <= 0;
      writes_seen  <= 0;
      rects_done   <= 0;
      quiet_cycles <= 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) items_sent <= items_sent + 1;
      if (res_bus.valid && res_bus.ready) begin
        writes_seen <= writes_seen + int'(res_bus.write_valid);
        rects_done  <= rects_done + int'(res_bus.rect_done);
      end
      if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("no item moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver keeps a stall pattern for a while, then draws a new one.
  always @(negedge clk) begin
    if (pat_age == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      pat_age   = $urandom_range(20, 80);
    end
    pat_age--;
    res_bus.ready <= stall_pat[pat_pos];
    pat_pos = (pat_pos + 1) % 16;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_RECT_W) plan_w = val;
    if (idx == REG_RECT_H) plan_h = val;
    @(negedge clk);
  endtask

  task automatic close_writes();
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_pixels(input int count);
    int               left, burst, gap, roll;
    logic [PIX_W-1:0] word;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      gap   = $urandom_range(0, 6);
      while (burst > 0 && left > 0) begin
        roll = $urandom_range(0, 15);
        word = (roll == 0) ? '0 : (roll == 1) ? '1 : PIX_W'($urandom());
        if (directed_pix.size() > 0) word = directed_pix.pop_front();
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_value <= word;
        do @(posedge clk); while (!pix_bus.ready);
        @(negedge clk);
        burst--;
        left--;
      end
      if (left == 0 || gap > 0) pix_bus.valid <= 1'b0;
      if (left > 0) repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
    int roll;
    roll = $urandom_range(0, 9);
    case (idx)
      REG_RECT_X, REG_RECT_Y:
        return (roll == 0) ? CFG_DATA_W'(4095) :
               (roll == 1) ? CFG_DATA_W'($urandom()) : CFG_DATA_W'($urandom_range(0, 52));
      REG_RECT_W, REG_RECT_H:
        return (roll == 0) ? CFG_DATA_W'(0) :
               (roll == 1) ? CFG_DATA_W'($urandom_range(4096, 8191)) :
               (roll == 2) ? CFG_DATA_W'($urandom()) : CFG_DATA_W'($urandom_range(1, 9));
      default:
        return (roll == 0) ? CFG_DATA_W'(0) :
               (roll == 1) ? CFG_DATA_W'(4096) :
               (roll == 2) ? CFG_DATA_W'($urandom()) : CFG_DATA_W'($urandom_range(1, 48));
    endcase
  endfunction

  initial begin
    int w_eff, h_eff, area, count;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel_value = '0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    settings_used       = 0;
    plan_w              = '0;
    plan_h              = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty rectangle straight out of reset, with both extreme pixel words.
    directed_pix.push_back('0);
    directed_pix.push_back('1);
    send_pixels(2);
    drain();

    // A small rectangle fully inside the default framebuffer.
    write_reg(REG_RECT_X, 3);
    write_reg(REG_RECT_Y, 2);
    write_reg(REG_RECT_W, 3);
    write_reg(REG_RECT_H, 2);
    close_writes();
    send_pixels(6);
    drain();

    // Corner placement with oversized sizes; the first item lands on the top index.
    write_reg(REG_RECT_X, 13'h1FFF);
    write_reg(REG_RECT_Y, 4095);
    write_reg(REG_RECT_W, 8191);
    write_reg(REG_RECT_H, 8191);
    write_reg(REG_FB_WIDTH, 4096);
    write_reg(REG_FB_HEIGHT, 4096);
    close_writes();
    send_pixels(3);
    drain();

    // Left edge past the framebuffer width, then a rectangle clipped only at the bottom edge.
    write_reg(REG_FB_WIDTH, 10);
    write_reg(REG_FB_HEIGHT, 10);
    write_reg(REG_RECT_X, 12);
    write_reg(REG_RECT_Y, 9);
    write_reg(REG_RECT_W, 2);
    write_reg(REG_RECT_H, 2);
    close_writes();
    send_pixels(4);
    drain();
    write_reg(REG_RECT_X, 8);
    close_writes();
    send_pixels(4);
    drain();

    // Writes to unused indexes in the middle of a rectangle must not restart it.
    write_reg(REG_RECT_X, 0);
    write_reg(REG_RECT_Y, 0);
    write_reg(REG_RECT_W, 3);
    close_writes();
    send_pixels(2);
    drain();
    write_reg(REG_SPARE_HI, 13'h1FFF);
    write_reg(REG_SPARE_LO, 13'h0AAA);
    close_writes();
    send_pixels(4);

    while (items_sent < ITEM_TARGET) begin
      drain();
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(0, 9) < 6) write_reg(ALL_REGS[k], pick_reg(ALL_REGS[k]));
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom()));
      end
      close_writes();
      w_eff = (plan_w > MAX_DIM) ? MAX_DIM : plan_w;
      h_eff = (plan_h > MAX_DIM) ? MAX_DIM : plan_h;
      area  = w_eff * h_eff;
      if (area == 0) count = $urandom_range(1, 6);
      else if (area <= 60) count = area * $urandom_range(1, 3) + $urandom_range(0, 2);
      else count = $urandom_range(20, 120);
      if ($urandom_range(0, 4) == 0) begin
        send_pixels(count / 2);
        drain();
        send_pixels(count - count / 2);
      end else begin
        send_pixels(count);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Covered %0d pixel items over %0d register phases.", items_sent, settings_used);
    $display("Of the results, %0d fell inside the clip and %0d closed a rectangle.",
             writes_seen, rects_done);
    if (mismatches == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cbi_pkg.sv
rtl/core/cbi_if.sv
rtl/core/cbi_geom.sv
rtl/core/clipped_rect_blit_index_top.sv
bench/cbi_blit_checker.sv
bench/tb.sv
